@@ rtl/eecl_pkg.sv @@
// Shared types and constants for the engine event capture logger.
// Holds the event codes, the request and record structs and the config struct.
// No dependencies.
`default_nettype none

package eecl_pkg;

  localparam int CamChannelsDef    = 4;
  localparam int OutputChannelsDef = 8;
  localparam int CamFieldW         = 4;
  localparam int OutFieldW         = 8;
  localparam int TimeW             = 63;
  localparam int ApbAddrW          = 3;
  localparam int ApbDataW          = 32;

  typedef enum logic [2:0] {
    CmdPrimary  = 3'd0,
    CmdCam      = 3'd1,
    CmdTdc      = 3'd2,
    CmdSync     = 3'd3,
    CmdCoil     = 3'd4,
    CmdInjector = 3'd5,
    CmdAcr      = 3'd6
  } cmd_e;

  typedef enum logic {
    RegLoggerEnabled   = 1'b0,
    RegPrimaryToothOnly = 1'b1
  } reg_idx_e;

  typedef struct packed {
    cmd_e             command;
    logic [3:0]       channel_index;
    logic             level;
    logic [TimeW-1:0] event_time;
    logic             capture_allowed;
  } in_item_t;

  typedef struct packed {
    logic [TimeW-1:0]     record_time;
    logic                 primary_state;
    logic [CamFieldW-1:0] cam_states;
    logic                 from_cam;
    logic                 tdc_toggle;
    logic                 sync_state;
    logic [OutFieldW-1:0] coil_bits;
    logic [OutFieldW-1:0] injector_bits;
    logic                 acr_state;
  } out_item_t;

  typedef struct packed {
    logic logger_enabled;
    logic primary_tooth_only;
  } cfg_t;

endpackage

`default_nettype wire

@@ rtl/engine_event_capture_logger_core.sv @@
// Engine event capture logger: takes one timestamped engine event per cycle,
// keeps a snapshot of all signal levels and emits the snapshot as a record when
// capture is enabled, allowed and not filtered by the primary-tooth-only mode.
// Each request is registered in the input register and is then updated into
// the output register, which presents its record on the output. One request
// per cycle is sustained as long as records are taken; a stalled record holds
// the next request in the input register, after which requests stop. Requests
// that produce no record leave only the state change. Configuration goes
// through the APB port and should change only while no request is in flight.
// Depends on eecl_pkg, eecl_regs and eecl_update.
`default_nettype none

module engine_event_capture_logger_core
  import eecl_pkg::*;
#(
  parameter int CAM_CHANNELS    = CamChannelsDef,
  parameter int OUTPUT_CHANNELS = OutputChannelsDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire in_item_t            in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output out_item_t                out_data_o,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [ApbAddrW-1:0] paddr,
  input  wire logic [ApbDataW-1:0] pwdata,
  output logic      [ApbDataW-1:0] prdata,
  output logic                     pready
);

  cfg_t      cfg;
  in_item_t  item_q;
  logic      item_valid_q;
  out_item_t rec, out_q;
  logic      out_valid_q;
  logic      out_free, advance, log_rec;

  eecl_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  eecl_update #(
    .CAM_CHANNELS    (CAM_CHANNELS),
    .OUTPUT_CHANNELS (OUTPUT_CHANNELS)
  ) u_update (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .item_i (item_q),
    .step_i (advance),
    .log_o  (log_rec),
    .rec_o  (rec)
  );

  assign out_free   = !out_valid_q || out_ready_i;
  assign advance    = item_valid_q && out_free;
  assign in_ready_o = !item_valid_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (in_ready_o) begin
        item_valid_q <= in_valid_i;
      end
      if (out_free) begin
        out_valid_q <= advance && log_rec;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_data_i;
    end
    if (advance && log_rec) begin
      out_q <= rec;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

@@ rtl/eecl_regs.sv @@
// APB-style configuration registers of the event capture logger.
// Depends on eecl_pkg for the address width and the register indexes.
`default_nettype none

module eecl_regs
  import eecl_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [ApbAddrW-1:0] paddr,
  input  wire logic [ApbDataW-1:0] pwdata,
  output logic      [ApbDataW-1:0] prdata,
  output logic                     pready,
  output cfg_t                     cfg_o
);

  cfg_t     cfg_q, cfg_d;
  reg_idx_e reg_idx;
  logic     wr_en;

  // Registers sit on word addresses; the low address bits do not select.
  assign reg_idx = reg_idx_e'(paddr[2]);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_idx)
        RegLoggerEnabled:    cfg_d.logger_enabled     = pwdata[0];
        RegPrimaryToothOnly: cfg_d.primary_tooth_only = pwdata[0];
        default:             cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      RegLoggerEnabled:    prdata[0] = cfg_q.logger_enabled;
      RegPrimaryToothOnly: prdata[0] = cfg_q.primary_tooth_only;
      default:             prdata    = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

@@ rtl/eecl_update.sv @@
// Signal snapshot state and the per-event update and filter logic.
// Depends on eecl_pkg for the event codes, the request and record structs.
`default_nettype none

module eecl_update
  import eecl_pkg::*;
#(
  parameter int CAM_CHANNELS    = CamChannelsDef,
  parameter int OUTPUT_CHANNELS = OutputChannelsDef
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire cfg_t     cfg_i,
  input  wire in_item_t item_i,
  input  wire logic     step_i,
  output logic          log_o,
  output out_item_t     rec_o
);

  localparam int CamExtW = (CAM_CHANNELS > CamFieldW) ? CAM_CHANNELS : CamFieldW;
  localparam int OutExtW = (OUTPUT_CHANNELS > OutFieldW) ? OUTPUT_CHANNELS : OutFieldW;

  logic                       primary_q, primary_d;
  logic [CAM_CHANNELS-1:0]    cam_q, cam_d;
  logic                       cam_last_q, cam_last_d;
  logic                       tdc_q, tdc_d;
  logic                       sync_q, sync_d;
  logic [OUTPUT_CHANNELS-1:0] coil_q, coil_d;
  logic [OUTPUT_CHANNELS-1:0] inj_q, inj_d;
  logic                       acr_q, acr_d;

  logic                       cam_hit, out_hit, ptm, log_evt;
  logic [CAM_CHANNELS-1:0]    cam_set;
  logic [OUTPUT_CHANNELS-1:0] out_set;
  logic [CamExtW-1:0]         cam_ext;
  logic [OutExtW-1:0]         coil_ext, inj_ext;

  assign ptm     = cfg_i.primary_tooth_only;
  assign cam_hit = int'(item_i.channel_index) < CAM_CHANNELS;
  assign out_hit = int'(item_i.channel_index) < OUTPUT_CHANNELS;

  // Cam mask with the addressed bit replaced by the event level; one-hot mask of the addressed output bit.
  always_comb begin
    cam_set = cam_q;
    for (int i = 0; i < CAM_CHANNELS; i++) begin
      if (int'(item_i.channel_index) == i) cam_set[i] = item_i.level;
    end
  end

  always_comb begin
    out_set = '0;
    for (int i = 0; i < OUTPUT_CHANNELS; i++) begin
      out_set[i] = (int'(item_i.channel_index) == i);
    end
  end

  always_comb begin
    primary_d  = primary_q;
    cam_d      = cam_q;
    cam_last_d = cam_last_q;
    tdc_d      = tdc_q;
    sync_d     = sync_q;
    coil_d     = coil_q;
    inj_d      = inj_q;
    acr_d      = acr_q;
    log_evt    = 1'b0;
    unique case (item_i.command)
      CmdPrimary: begin
        cam_last_d = 1'b0;
        primary_d  = item_i.level;
        log_evt    = !(ptm && !item_i.level);
      end
      CmdCam: begin
        if (cam_hit) begin
          cam_last_d = 1'b1;
          cam_d      = cam_set;
          log_evt    = !ptm;
        end
      end
      CmdTdc: begin
        // Primary-tooth-only mode leaves the TDC flag alone.
        if (!ptm) begin
          tdc_d   = !tdc_q;
          log_evt = 1'b1;
        end
      end
      CmdSync: begin
        sync_d  = item_i.level;
        log_evt = 1'b1;
      end
      CmdCoil: begin
        if (out_hit) begin
          coil_d  = item_i.level ? (coil_q | out_set) : (coil_q & ~out_set);
          log_evt = !ptm;
        end
      end
      CmdInjector: begin
        if (out_hit) begin
          inj_d   = item_i.level ? (inj_q | out_set) : (inj_q & ~out_set);
          log_evt = !ptm;
        end
      end
      CmdAcr: begin
        // An unchanged ACR state is not an event.
        if (acr_q != item_i.level) begin
          acr_d   = item_i.level;
          log_evt = !ptm;
        end
      end
      default: log_evt = 1'b0;
    endcase
  end

  assign log_o = log_evt && cfg_i.logger_enabled && item_i.capture_allowed;

  // Channels beyond the record fields are kept but not shown.
  assign cam_ext  = CamExtW'(cam_d);
  assign coil_ext = OutExtW'(coil_d);
  assign inj_ext  = OutExtW'(inj_d);

  always_comb begin
    rec_o.record_time   = item_i.event_time;
    rec_o.primary_state = primary_d;
    rec_o.cam_states    = cam_ext[CamFieldW-1:0];
    rec_o.from_cam      = cam_last_d;
    rec_o.tdc_toggle    = tdc_d;
    rec_o.sync_state    = sync_d;
    rec_o.coil_bits     = coil_ext[OutFieldW-1:0];
    rec_o.injector_bits = inj_ext[OutFieldW-1:0];
    rec_o.acr_state     = acr_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      primary_q  <= 1'b0;
      cam_q      <= '0;
      cam_last_q <= 1'b0;
      tdc_q      <= 1'b0;
      sync_q     <= 1'b0;
      coil_q     <= '0;
      inj_q      <= '0;
      acr_q      <= 1'b0;
    end else if (step_i) begin
      primary_q  <= primary_d;
      cam_q      <= cam_d;
      cam_last_q <= cam_last_d;
      tdc_q      <= tdc_d;
      sync_q     <= sync_d;
      coil_q     <= coil_d;
      inj_q      <= inj_d;
      acr_q      <= acr_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/eecl_checker.sv @@
// Port-level checks for the engine event capture logger core, bound to the top.
// Depends on eecl_pkg for the payload types.
`default_nettype none

module eecl_checker
  import eecl_pkg::*;
(
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_valid_i,
  input wire logic                in_ready_o,
  input wire logic                out_valid_o,
  input wire logic                out_ready_i,
  input wire out_item_t           out_data_o,
  input wire logic                psel,
  input wire logic                penable,
  input wire logic                pready
);

  // A record that stalls stays on the port unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("record dropped or changed while stalled");

  // A fresh record must be preceded by an accepted request.
  a_out_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o, 2))
    else $error("record without a matching request");

  // Requests are refused only while a record is stalled at the output.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("request refused without output backpressure");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable |-> pready)
    else $error("configuration access stalled");

endmodule

bind engine_event_capture_logger_core eecl_checker u_checker (.*);

`default_nettype wire
